### sv/tmtt_pkg.sv
// Shared constants and types of the tempo-map tick-to-time converter.
`default_nettype none
package tmtt_pkg;

	// Table geometry
	localparam int TEMPO_ENTRIES     = 64;
	localparam int IDX_W             = (TEMPO_ENTRIES > 1) ? $clog2(TEMPO_ENTRIES) : 1;
	localparam int CNT_W             = $clog2(TEMPO_ENTRIES + 1);

	// Field widths
	localparam int TICK_W            = 32;
	localparam int TEMPO_W           = 10;
	localparam int LEN_W             = 24;
	localparam int DUR_W             = 32;
	localparam int ENTRY_W           = TICK_W + TEMPO_W;

	// Time base: microseconds per minute over tempo times ticks per quarter
	localparam int TICKS_PER_QUARTER = 480;
	localparam int TPQ_W             = $clog2(TICKS_PER_QUARTER + 1);
	localparam int US_PER_MIN        = 60000000;
	localparam int US_PER_MIN_W      = 26;
	localparam int DEN_W             = TEMPO_W + TPQ_W;
	localparam int NUM_W             = US_PER_MIN_W + LEN_W;
	localparam int DSH_W             = DEN_W + DUR_W;
	localparam int BIT_W             = $clog2(DUR_W);

	localparam logic [TEMPO_W-1:0] DEFAULT_TEMPO = TEMPO_W'(120);

	// Item kinds
	localparam logic [1:0] KIND_LOAD  = 2'd0;
	localparam logic [1:0] KIND_TRACK = 2'd1;
	localparam logic [1:0] KIND_NOTE  = 2'd2;

	// Request to the shared divider
	typedef struct packed {
		logic               go;
		logic [LEN_W-1:0]   ticks;
		logic [TEMPO_W-1:0] tempo;
	} piece_req_t;

	// Answer from the shared divider
	typedef struct packed {
		logic             done;
		logic [DUR_W-1:0] quot;
	} piece_rsp_t;

endpackage
`default_nettype wire

### sv/tmtt_ram.sv
// Generic single-port-write, registered-read RAM.
`default_nettype none
module tmtt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                                   clk,
	input  wire logic                                   we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                       wdata,
	input  wire logic                                   re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

### sv/tmtt_div.sv
// Shared iterative unit: floor(US_PER_MIN*ticks / (tempo*TICKS_PER_QUARTER)), saturating.
`default_nettype none
module tmtt_div (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire tmtt_pkg::piece_req_t req,
	output tmtt_pkg::piece_rsp_t      rsp
);

	localparam logic [1:0] D_IDLE = 2'd0;
	localparam logic [1:0] D_MUL  = 2'd1;
	localparam logic [1:0] D_CHK  = 2'd2;
	localparam logic [1:0] D_ITER = 2'd3;

	logic [1:0]                       state_q;
	logic [tmtt_pkg::LEN_W-1:0]       ticks_q;
	logic [tmtt_pkg::TEMPO_W-1:0]     tempo_q;
	logic [tmtt_pkg::DSH_W-1:0]       rem_q;
	logic [tmtt_pkg::DEN_W-1:0]       den_q;
	logic [tmtt_pkg::DSH_W-1:0]       dsh_q;
	logic [tmtt_pkg::BIT_W-1:0]       bit_q;
	logic [tmtt_pkg::DUR_W-1:0]       quot_q;
	logic                             done_q;
	logic [tmtt_pkg::NUM_W-1:0]       num_prod;
	logic [tmtt_pkg::DEN_W-1:0]       den_prod;
	logic [tmtt_pkg::DSH_W-1:0]       den_top;
	logic                             rem_ge;

	// Numerator and denominator products
	assign num_prod = tmtt_pkg::NUM_W'(tmtt_pkg::US_PER_MIN) * tmtt_pkg::NUM_W'(ticks_q);
	assign den_prod = tmtt_pkg::DEN_W'(tempo_q) *
		tmtt_pkg::DEN_W'(tmtt_pkg::TICKS_PER_QUARTER);

	// Quotient overflow bound and restoring step compare
	assign den_top = {den_q, {tmtt_pkg::DUR_W{1'b0}}};
	assign rem_ge  = (rem_q >= dsh_q);

	assign rsp.done = done_q;
	assign rsp.quot = quot_q;

	// Control: sequence multiply, overflow check and one quotient bit a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= D_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				D_IDLE: begin
					if (req.go) begin
						state_q <= D_MUL;
					end
				end
				D_MUL: begin
					if (ticks_q == '0) begin
						done_q  <= 1'b1;
						state_q <= D_IDLE;
					end else begin
						state_q <= D_CHK;
					end
				end
				D_CHK: begin
					if (rem_q >= den_top) begin
						done_q  <= 1'b1;
						state_q <= D_IDLE;
					end else begin
						state_q <= D_ITER;
					end
				end
				D_ITER: begin
					if (bit_q == '0) begin
						done_q  <= 1'b1;
						state_q <= D_IDLE;
					end
				end
				default: begin
					state_q <= D_IDLE;
				end
			endcase
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		case (state_q)
			D_IDLE: begin
				if (req.go) begin
					ticks_q <= req.ticks;
					tempo_q <= req.tempo;
				end
			end
			D_MUL: begin
				rem_q  <= tmtt_pkg::DSH_W'(num_prod);
				den_q  <= den_prod;
				quot_q <= '0;
			end
			D_CHK: begin
				dsh_q  <= {1'b0, den_q, {(tmtt_pkg::DUR_W-1){1'b0}}};
				bit_q  <= tmtt_pkg::BIT_W'(tmtt_pkg::DUR_W - 1);
				quot_q <= (rem_q >= den_top) ? '1 : '0;
			end
			D_ITER: begin
				if (rem_ge) begin
					rem_q <= rem_q - dsh_q;
				end
				quot_q <= {quot_q[tmtt_pkg::DUR_W-2:0], rem_ge};
				dsh_q  <= dsh_q >> 1;
				bit_q  <= bit_q - 1'b1;
			end
			default: begin
			end
		endcase
	end

endmodule
`default_nettype wire

### sv/tempo_map_tick_to_time.sv
// Top level: tempo table, note sequencer and result register.
//
// Loads, track starts and unused kinds leave the sequencer idle: start is taken
// again the next cycle. A note walks the tempo table in ascending order and cuts
// its length at every tempo change it crosses; each piece goes through the shared
// divider (multiply, overflow check, 32 restoring steps), and each table entry
// visited costs a table read and compare. A zero-length piece ends the divide
// after the multiply. busy is high throughout. The result is shown for exactly
// one cycle with valid high, the cycle after the last piece; it cannot be held
// off, so the receiver must take it then. The table is not cleared after reset;
// entries are only used below the fill count.
`default_nettype none
module tempo_map_tick_to_time (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  kind,
	input  wire logic [31:0] entry_tick,
	input  wire logic [9:0]  entry_tempo,
	input  wire logic [7:0]  track_channel,
	input  wire logic [23:0] note_length,
	input  wire logic signed [7:0] note_tone,
	input  wire logic [6:0]  note_volume,
	input  wire logic [15:0] lyric_index,
	output logic             valid,
	output logic [7:0]       out_channel,
	output logic [31:0]      duration_us,
	output logic             is_pause,
	output logic [6:0]       out_tone,
	output logic [6:0]       out_volume,
	output logic [15:0]      out_lyric
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_CHK  = 3'd1;
	localparam logic [2:0] S_CMP  = 3'd2;
	localparam logic [2:0] S_GO   = 3'd3;
	localparam logic [2:0] S_WAIT = 3'd4;

	logic [2:0]                       state_q;
	logic [tmtt_pkg::CNT_W-1:0]       count_q;
	logic [tmtt_pkg::TICK_W-1:0]      position_q;
	logic [tmtt_pkg::TEMPO_W-1:0]     tempo_q;
	logic [tmtt_pkg::CNT_W-1:0]       next_q;
	logic [7:0]                       channel_q;
	logic [tmtt_pkg::TICK_W-1:0]      last_tick_q;
	logic [tmtt_pkg::TEMPO_W-1:0]     first_tempo_q;
	logic                             valid_q;

	// Note working registers
	logic [tmtt_pkg::TICK_W-1:0]      pos_q;
	logic [tmtt_pkg::LEN_W-1:0]       left_q;
	logic [tmtt_pkg::DUR_W-1:0]       sum_q;
	logic                             first_q;
	logic                             last_q;
	logic [tmtt_pkg::LEN_W-1:0]       piece_q;
	logic [7:0]                       tone_q;
	logic [6:0]                       volume_q;
	logic [15:0]                      lyric_q;

	logic                             accept;
	logic                             load_replace;
	logic                             load_append;
	logic [tmtt_pkg::CNT_W-1:0]       last_idx;
	logic                             ram_we;
	logic [tmtt_pkg::IDX_W-1:0]       ram_waddr;
	logic [tmtt_pkg::ENTRY_W-1:0]     ram_rdata;
	logic [tmtt_pkg::TICK_W-1:0]      nt;
	logic [tmtt_pkg::TEMPO_W-1:0]     ntempo;
	logic [tmtt_pkg::TICK_W:0]        pos_end;
	logic                             crosses;
	logic [tmtt_pkg::DUR_W:0]         sum_add;
	logic [tmtt_pkg::DUR_W-1:0]       sum_sat;
	logic [tmtt_pkg::TICK_W-1:0]      pos_sat;
	logic                             tone_pause;
	tmtt_pkg::piece_req_t             req;
	tmtt_pkg::piece_rsp_t             rsp;

	assign accept = start && (state_q == S_IDLE);
	assign busy   = (state_q != S_IDLE);
	assign valid  = valid_q;

	// Tempo entry load decision
	assign last_idx     = count_q - 1'b1;
	assign load_replace = (count_q != '0) && (entry_tick == last_tick_q);
	assign load_append  = !load_replace &&
		((count_q == '0) || (entry_tick > last_tick_q)) &&
		(count_q < tmtt_pkg::CNT_W'(tmtt_pkg::TEMPO_ENTRIES));
	assign ram_we    = accept && (kind == tmtt_pkg::KIND_LOAD) && (load_replace || load_append);
	assign ram_waddr = load_replace ? last_idx[tmtt_pkg::IDX_W-1:0]
	                                : count_q[tmtt_pkg::IDX_W-1:0];

	tmtt_ram #(
		.WIDTH (tmtt_pkg::ENTRY_W),
		.DEPTH (tmtt_pkg::TEMPO_ENTRIES)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata ({entry_tick, entry_tempo}),
		.re    (state_q == S_CHK),
		.raddr (next_q[tmtt_pkg::IDX_W-1:0]),
		.rdata (ram_rdata)
	);

	// Pending change and split test
	assign nt      = ram_rdata[tmtt_pkg::ENTRY_W-1:tmtt_pkg::TEMPO_W];
	assign ntempo  = ram_rdata[tmtt_pkg::TEMPO_W-1:0];
	assign pos_end = {1'b0, pos_q} + (tmtt_pkg::TICK_W+1)'(left_q);
	assign crosses = pos_end > {1'b0, nt};
	assign pos_sat = pos_end[tmtt_pkg::TICK_W] ? '1 : pos_end[tmtt_pkg::TICK_W-1:0];

	// Saturating accumulate of each piece
	assign sum_add = {1'b0, sum_q} + {1'b0, rsp.quot};
	assign sum_sat = sum_add[tmtt_pkg::DUR_W] ? '1 : sum_add[tmtt_pkg::DUR_W-1:0];

	assign tone_pause = (tone_q == 8'hFF);

	assign req.go    = (state_q == S_GO);
	assign req.ticks = piece_q;
	assign req.tempo = tempo_q;

	tmtt_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	// Sequencer and architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			count_q    <= '0;
			position_q <= '0;
			tempo_q    <= tmtt_pkg::DEFAULT_TEMPO;
			next_q     <= tmtt_pkg::CNT_W'(1);
			channel_q  <= '0;
			valid_q    <= 1'b0;
		end else begin
			valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (kind)
							tmtt_pkg::KIND_LOAD: begin
								if (load_append) begin
									count_q <= count_q + 1'b1;
								end
							end
							tmtt_pkg::KIND_TRACK: begin
								position_q <= '0;
								tempo_q    <= (count_q != '0) ? first_tempo_q
								                              : tmtt_pkg::DEFAULT_TEMPO;
								next_q     <= tmtt_pkg::CNT_W'(1);
								channel_q  <= track_channel;
							end
							tmtt_pkg::KIND_NOTE: begin
								state_q <= S_CHK;
							end
							default: begin
							end
						endcase
					end
				end
				S_CHK: begin
					state_q <= (next_q < count_q) ? S_CMP : S_GO;
				end
				S_CMP: begin
					if (!first_q && (pos_q >= nt)) begin
						tempo_q <= ntempo;
						next_q  <= next_q + 1'b1;
						state_q <= S_CHK;
					end else if (first_q && crosses && (pos_q >= nt)) begin
						tempo_q <= ntempo;
						next_q  <= next_q + 1'b1;
						state_q <= S_CHK;
					end else begin
						state_q <= S_GO;
					end
				end
				S_GO: begin
					state_q <= S_WAIT;
				end
				S_WAIT: begin
					if (rsp.done) begin
						if (last_q) begin
							position_q <= pos_sat;
							valid_q    <= 1'b1;
							state_q    <= S_IDLE;
						end else begin
							state_q <= S_CHK;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Note datapath, table shadows and result register
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept && (kind == tmtt_pkg::KIND_LOAD)) begin
					if (load_replace && (count_q == tmtt_pkg::CNT_W'(1))) begin
						first_tempo_q <= entry_tempo;
					end
					if (load_append) begin
						last_tick_q <= entry_tick;
						if (count_q == '0) begin
							first_tempo_q <= entry_tempo;
						end
					end
				end
				if (accept && (kind == tmtt_pkg::KIND_NOTE)) begin
					pos_q    <= position_q;
					left_q   <= note_length;
					sum_q    <= '0;
					first_q  <= 1'b1;
					tone_q   <= note_tone;
					volume_q <= note_volume;
					lyric_q  <= lyric_index;
				end
			end
			S_CHK: begin
				// No change pending: the rest of the note is one piece
				if (next_q >= count_q) begin
					piece_q <= left_q;
					last_q  <= 1'b1;
				end
			end
			S_CMP: begin
				if (first_q && !crosses) begin
					piece_q <= left_q;
					last_q  <= 1'b1;
				end else if (pos_q >= nt) begin
					first_q <= 1'b0;
				end else if (crosses) begin
					// Cut at the change and keep the rest for later
					piece_q <= tmtt_pkg::LEN_W'(nt - pos_q);
					left_q  <= left_q - tmtt_pkg::LEN_W'(nt - pos_q);
					pos_q   <= nt;
					last_q  <= 1'b0;
					first_q <= 1'b0;
				end else begin
					piece_q <= left_q;
					last_q  <= 1'b1;
				end
			end
			S_WAIT: begin
				if (rsp.done) begin
					sum_q <= sum_sat;
					if (last_q) begin
						out_channel <= channel_q;
						duration_us <= sum_sat;
						is_pause    <= tone_pause;
						out_tone    <= tone_pause ? 7'd0 : tone_q[6:0];
						out_volume  <= volume_q;
						out_lyric   <= lyric_q;
					end
				end
			end
			default: begin
			end
		endcase
	end

endmodule
`default_nettype wire
